FILE: hdl/assert_macros.svh
// assertion macros used by the snmp_get_request_parser rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked on the same edge
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication checked on the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: hdl/snmp_pkg.sv
// package for the snmp get request parser: phases, codes, constants
// no dependencies
`timescale 1ns / 1ps
package snmp_pkg;
  localparam int MaxDatagram = 2048;
  localparam int ReqIdBytes  = 8;
  localparam int CommMax     = 23;
  localparam int PrefixLen   = 9;

  typedef enum logic [3:0] {
    PH_OUTER, PH_VER, PH_COMM, PH_PDU, PH_REQID, PH_ES, PH_EI,
    PH_VBL, PH_VB, PH_OID, PH_VAL, PH_DONE, PH_HALT
  } phase_t;

  typedef enum logic [1:0] {HS_TAG, HS_LEN, HS_LONG, HS_CONTENT} hstep_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_PARSE = 2'd1, ST_AUTH = 2'd2, ST_LONG_ID = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_COMM0 = 2'd0, CFG_COMM1 = 2'd1, CFG_COMM2 = 2'd2, CFG_COMM_LEN = 2'd3
  } cfg_index_t;

  localparam logic [7:0] TagSeq = 8'h30;
  localparam logic [7:0] TagInt = 8'h02;
  localparam logic [7:0] TagOct = 8'h04;
  localparam logic [7:0] TagPdu = 8'hA0;
  localparam logic [7:0] TagOid = 8'h06;

  // fixed oid prefix byte
  function automatic logic [7:0] oid_prefix(input logic [3:0] i);
    case (i)
      4'd0: oid_prefix = 8'h2B;
      4'd1: oid_prefix = 8'h06;
      4'd2: oid_prefix = 8'h01;
      4'd3: oid_prefix = 8'h04;
      4'd4: oid_prefix = 8'h01;
      4'd5: oid_prefix = 8'h83;
      4'd6: oid_prefix = 8'hB2;
      4'd7: oid_prefix = 8'h03;
      4'd8: oid_prefix = 8'h01;
      default: oid_prefix = 8'h00;
    endcase
  endfunction

  // byte step inputs as seen by the parse core
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } byte_in_t;

  // one finished result
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  metric;
    logic [7:0]  version;
    logic [63:0] req_id;
    logic [3:0]  req_id_len;
  } result_t;
endpackage

FILE: hdl/snmp_get_request_parser.sv
// snmp get request parser: one datagram byte per transfer, one result per datagram
// a datagram's result passes the core's result register and then the output queue before m_axis_tvalid rises
// throughput: one byte per cycle; input stalls only while the 2-entry queue cannot take more
// reset: rst (synchronous, active high) clears parse state, community registers and queue
// depends on snmp_pkg, snmp_cfg, snmp_core, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module snmp_get_request_parser import snmp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte [7:0]
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // status, metric_index, version, request_id,
                                      // request_id_length, zero pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  logic [183:0] community;
  logic [4:0]   community_length;
  byte_in_t     in_byte;
  logic         res_valid;
  result_t      res;
  result_t      q0, q1;
  logic         v0, v1;

  snmp_cfg u_cfg (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .community, .community_length
  );

  // stall input only when the queue is full or holds one with a result in flight
  assign s_axis_tready = !v1 && !(v0 && res_valid);
  assign in_byte = '{valid: s_axis_tvalid && s_axis_tready,
                     data: s_axis_tdata, last: s_axis_tlast};

  snmp_core u_core (
    .clk, .rst, .in_byte, .community, .community_length, .res_valid, .res
  );

  // two-entry output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (v1) begin q0 <= q1; v1 <= res_valid; q1 <= res; end
        else begin v0 <= res_valid; q0 <= res; end
      end else if (res_valid) begin
        if (!v0) begin v0 <= 1'b1; q0 <= res; end
        else begin v1 <= 1'b1; q1 <= res; end
      end
    end
  end

  assign m_axis_tvalid = v0;
  assign m_axis_tdata = {2'b00, q0.req_id_len, q0.req_id, q0.version, q0.metric, q0.status};

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, v1 && res_valid, 1'b0, "queue overflow")
  `ASSERT_IMPLIES(a_order, clk, rst, v1, v0, "queue entries out of order")
  `ASSERT_NEXT(a_result, clk, rst, in_byte.valid && in_byte.last, res_valid,
               "missing result after last byte")
endmodule

FILE: hdl/snmp_cfg.sv
// configuration registers of the snmp parser: community string and length
// depends on snmp_pkg
`timescale 1ns / 1ps
module snmp_cfg import snmp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  output logic [183:0] community,
  output logic [4:0]   community_length
);
  logic [63:0] comm0, comm1;
  logic [55:0] comm2;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      comm0 <= '0;
      comm1 <= '0;
      comm2 <= '0;
      community_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COMM0:    comm0 <= cfg_data;
        CFG_COMM1:    comm1 <= cfg_data;
        CFG_COMM2:    comm2 <= cfg_data[55:0];
        CFG_COMM_LEN: community_length <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign community = {comm2, comm1, comm0};
endmodule

FILE: hdl/snmp_core.sv
// ber walk of one datagram, one byte per cycle while in_byte.valid is high, result registered on the last byte
// depends on snmp_pkg
`timescale 1ns / 1ps
module snmp_core import snmp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  byte_in_t     in_byte,
  input  logic [183:0] community,
  input  logic [4:0]   community_length,
  output logic         res_valid,
  output result_t      res
);
  logic [11:0] offset;
  phase_t      phase;
  hstep_t      hstep;
  logic [15:0] len_acc;
  logic [1:0]  long_cnt;
  logic [15:0] encl [4];
  logic [15:0] elem_end;
  logic [4:0]  cidx;
  logic        comm_ok, prefix_ok;
  logic [1:0]  err;
  logic [7:0]  metric, version;
  logic [63:0] req_id;
  logic [3:0]  id_len;
  logic [15:0] comm_len;
  logic        id_ovf;

  phase_t      phase_n;
  hstep_t      hstep_n;
  logic [15:0] len_acc_n, elem_end_n, comm_len_n;
  logic [1:0]  long_cnt_n, err_n;
  logic [15:0] encl_n [4];
  logic [4:0]  cidx_n;
  logic        comm_ok_n, prefix_ok_n, id_ovf_n;
  logic [7:0]  metric_n, version_n;
  logic [63:0] req_id_n;
  logic [3:0]  id_len_n;

  logic [1:0]  plev;
  logic [15:0] parent_end, o16, lval;
  logic [16:0] o_ext;
  logic        tag_good, hdr_go, fin_go;
  logic [7:0]  b;
  logic [1:0]  status_c;

  assign b = in_byte.data;
  assign o16 = {4'd0, offset};
  assign o_ext = {1'b0, o16};

  // parent level of the current element
  always_comb begin
    if (phase <= PH_PDU) plev = 2'd0;
    else if (phase <= PH_VBL) plev = 2'd1;
    else if (phase == PH_VB) plev = 2'd2;
    else plev = 2'd3;
  end
  assign parent_end = encl[plev];

  // tag check
  always_comb begin
    case (phase)
      PH_OUTER, PH_VBL, PH_VB: tag_good = (b == TagSeq);
      PH_VER, PH_REQID:        tag_good = (b == TagInt);
      PH_COMM:                 tag_good = (b == TagOct);
      PH_PDU:                  tag_good = (b == TagPdu);
      PH_OID:                  tag_good = (b == TagOid);
      default:                 tag_good = 1'b1;
    endcase
  end

  // parse step
  always_comb begin
    logic [16:0] endw;
    logic [7:0]  cb;
    phase_n = phase; hstep_n = hstep; len_acc_n = len_acc; long_cnt_n = long_cnt;
    for (int k = 0; k < 4; k++) encl_n[k] = encl[k];
    elem_end_n = elem_end; cidx_n = cidx; comm_ok_n = comm_ok; prefix_ok_n = prefix_ok;
    err_n = err; metric_n = metric; version_n = version; req_id_n = req_id;
    id_len_n = id_len; comm_len_n = comm_len; id_ovf_n = id_ovf;
    hdr_go = 1'b0; fin_go = 1'b0; lval = len_acc;
    endw = '0; cb = '0;

    if ({4'd0, offset} >= 16'(MaxDatagram)) begin
      err_n = ST_PARSE; phase_n = PH_HALT;
    end else if (phase != PH_DONE && phase != PH_HALT) begin
      case (hstep)
        HS_TAG: begin
          if (phase != PH_OUTER && {1'b0, parent_end} < o_ext + 17'd2) begin
            err_n = ST_PARSE; phase_n = PH_HALT;
          end else if (!tag_good) begin
            err_n = ST_PARSE; phase_n = PH_HALT;
          end else hstep_n = HS_LEN;
        end
        HS_LEN: begin
          if (b[7]) begin
            if (b[6:0] == 7'd0 || b[6:0] > 7'd2) begin
              err_n = ST_PARSE; phase_n = PH_HALT;
            end else if (phase != PH_OUTER &&
                         {1'b0, parent_end} < o_ext + 17'd1 + {15'd0, b[1:0]}) begin
              err_n = ST_PARSE; phase_n = PH_HALT;
            end else begin
              long_cnt_n = b[1:0]; len_acc_n = '0; hstep_n = HS_LONG;
            end
          end else begin
            lval = {8'd0, b}; len_acc_n = lval; hdr_go = 1'b1;
          end
        end
        HS_LONG: begin
          lval = {len_acc[7:0], b}; len_acc_n = lval;
          long_cnt_n = long_cnt - 2'd1;
          hdr_go = (long_cnt == 2'd1);
        end
        default: begin
          case (phase)
            PH_VER: version_n = b;
            PH_COMM: begin
              cb = community[{cidx, 3'b000} +: 8];
              if (cidx >= 5'(CommMax) || cb != b) comm_ok_n = 1'b0;
            end
            PH_REQID: begin
              req_id_n = {req_id[55:0], b};
              if (id_len < 4'(ReqIdBytes)) id_len_n = id_len + 4'd1;
              else id_ovf_n = 1'b1;
            end
            PH_OID: begin
              if (cidx < 5'(PrefixLen)) begin
                if (oid_prefix(cidx[3:0]) != b) prefix_ok_n = 1'b0;
              end else if (cidx == 5'(PrefixLen)) metric_n = b;
            end
            default: ;
          endcase
          if (cidx < 5'd31) cidx_n = cidx + 5'd1;
          fin_go = (o_ext + 17'd1 >= {1'b0, elem_end});
        end
      endcase

      // header complete
      if (hdr_go) begin
        endw = o_ext + 17'd1 + {1'b0, lval};
        if (phase != PH_OUTER && endw > {1'b0, parent_end}) begin
          err_n = ST_PARSE; phase_n = PH_HALT;
        end else begin
          hstep_n = HS_TAG;
          case (phase)
            PH_OUTER: begin encl_n[0] = endw[15:0]; phase_n = PH_VER; end
            PH_PDU: begin
              if (comm_len != {11'd0, community_length} || !comm_ok) begin
                err_n = ST_AUTH; phase_n = PH_HALT;
              end else begin encl_n[1] = endw[15:0]; phase_n = PH_REQID; end
            end
            PH_VBL: begin encl_n[2] = endw[15:0]; phase_n = PH_VB; end
            PH_VB:  begin encl_n[3] = endw[15:0]; phase_n = PH_OID; end
            PH_VAL: phase_n = PH_DONE;
            default: begin
              if (phase == PH_VER && lval != 16'd1) begin
                err_n = ST_PARSE; phase_n = PH_HALT;
              end else begin
                if (phase == PH_COMM) comm_len_n = lval;
                elem_end_n = endw[15:0]; cidx_n = '0; hstep_n = HS_CONTENT;
                fin_go = (lval == 16'd0);
              end
            end
          endcase
        end
      end

      // element content complete
      if (fin_go) begin
        hstep_n = HS_TAG;
        case (phase)
          PH_VER:   phase_n = PH_COMM;
          PH_COMM:  phase_n = PH_PDU;
          PH_REQID: phase_n = PH_ES;
          PH_ES:    phase_n = PH_EI;
          PH_EI:    phase_n = PH_VBL;
          PH_OID: begin
            if (len_acc_n == 16'(PrefixLen + 1) && prefix_ok_n) phase_n = PH_VAL;
            else begin err_n = ST_PARSE; phase_n = PH_HALT; end
          end
          default: begin err_n = ST_PARSE; phase_n = PH_HALT; end
        endcase
      end
    end
  end

  // status on the last byte
  always_comb begin
    if (err_n == ST_PARSE) status_c = ST_PARSE;
    else if (phase_n == PH_DONE || err_n == ST_AUTH) begin
      if ({1'b0, encl_n[0]} > o_ext + 17'd1) status_c = ST_PARSE;
      else if (err_n == ST_AUTH) status_c = ST_AUTH;
      else status_c = id_ovf_n ? ST_LONG_ID : ST_OK;
    end else status_c = ST_PARSE;
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst || (in_byte.valid && in_byte.last)) begin
      offset <= '0; phase <= PH_OUTER; hstep <= HS_TAG; len_acc <= '0;
      long_cnt <= '0;
      for (int k = 0; k < 4; k++) encl[k] <= '0;
      elem_end <= '0; cidx <= '0; comm_ok <= 1'b1; prefix_ok <= 1'b1;
      err <= '0; metric <= '0; version <= '0; req_id <= '0; id_len <= '0;
      comm_len <= '0; id_ovf <= 1'b0;
    end else if (in_byte.valid) begin
      if ({4'd0, offset} < 16'(MaxDatagram)) offset <= offset + 12'd1;
      phase <= phase_n; hstep <= hstep_n; len_acc <= len_acc_n;
      long_cnt <= long_cnt_n;
      for (int k = 0; k < 4; k++) encl[k] <= encl_n[k];
      elem_end <= elem_end_n; cidx <= cidx_n; comm_ok <= comm_ok_n;
      prefix_ok <= prefix_ok_n; err <= err_n; metric <= metric_n;
      version <= version_n; req_id <= req_id_n; id_len <= id_len_n;
      comm_len <= comm_len_n; id_ovf <= id_ovf_n;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else res_valid <= in_byte.valid && in_byte.last;
  end
  always_ff @(posedge clk) begin
    if (in_byte.valid && in_byte.last) begin
      res.status <= status_c;
      if (status_c == ST_OK || status_c == ST_LONG_ID) begin
        res.metric <= metric_n; res.version <= version_n;
        res.req_id <= req_id_n; res.req_id_len <= id_len_n;
      end else begin
        res.metric <= '0; res.version <= '0; res.req_id <= '0; res.req_id_len <= '0;
      end
    end
  end
endmodule

FILE: tb/sv/snmp_get_request_parser_tb.sv
// testbench for snmp_get_request_parser: streams snmp datagrams byte by byte
// and checks every result transfer against a cycle-free parse predictor
// depends on snmp_pkg and the snmp_get_request_parser rtl
`timescale 1ns / 1ps
module snmp_get_request_parser_tb;
  import snmp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;  // data_byte [7:0]
  logic        s_axis_tlast = 1'b0; // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;       // status, metric_index, version, request_id,
                                   // request_id_length, zero pad
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  int gap_pct = 0;
  int stall_pct = 0;
  int fails = 0;
  int cycles = 0;
  result_t result_q[$];

  localparam logic [7:0] PrefixBytes [9] = '{8'h2B, 8'h06, 8'h01, 8'h04, 8'h01,
                                             8'h83, 8'hB2, 8'h03, 8'h01};

  snmp_get_request_parser u_dut (.*);

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("snmp_get_request_parser: mismatch");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------- parse predictor ----------------
  logic [63:0] comm_w [3];
  int          comm_cfg_len;

  int          offs, eend, cidx, clen_seen, rlen, ekind;
  int          encl [4];
  phase_t      ph;
  hstep_t      hs;
  logic [15:0] lacc;
  int          lcnt;
  bit          comm_ok, pfx_ok, id_ovf;
  logic [7:0]  met, ver;
  logic [63:0] rid;

  task automatic clear_parse();
    offs = 0; ph = PH_OUTER; hs = HS_TAG; lacc = '0; lcnt = 0;
    encl = '{0, 0, 0, 0}; eend = 0; cidx = 0; comm_ok = 1; pfx_ok = 1;
    ekind = 0; met = '0; ver = '0; rid = '0; rlen = 0; clen_seen = 0; id_ovf = 0;
  endtask

  task automatic halt(int kind);
    ekind = kind;
    ph = PH_HALT;
  endtask

  function automatic int parent_lvl(phase_t p);
    if (p <= PH_PDU) return 0;
    if (p <= PH_VBL) return 1;
    if (p == PH_VB) return 2;
    return 3;
  endfunction

  function automatic bit tag_matches(phase_t p, logic [7:0] b);
    case (p)
      PH_OUTER, PH_VBL, PH_VB: return b == TagSeq;
      PH_VER, PH_REQID:        return b == TagInt;
      PH_COMM:                 return b == TagOct;
      PH_PDU:                  return b == TagPdu;
      PH_OID:                  return b == TagOid;
      default:                 return 1'b1;
    endcase
  endfunction

  task automatic close_element();
    hs = HS_TAG;
    case (ph)
      PH_VER:   ph = PH_COMM;
      PH_COMM:  ph = PH_PDU;
      PH_REQID: ph = PH_ES;
      PH_ES:    ph = PH_EI;
      PH_EI:    ph = PH_VBL;
      PH_OID: begin
        if (lacc == PrefixLen + 1 && pfx_ok) ph = PH_VAL;
        else halt(ST_PARSE);
      end
      default:  halt(ST_PARSE);
    endcase
  endtask

  task automatic header_complete(int o);
    int stop_at;
    stop_at = o + 1 + lacc;
    if (ph != PH_OUTER && stop_at > encl[parent_lvl(ph)]) begin
      halt(ST_PARSE);
      return;
    end
    hs = HS_TAG;
    case (ph)
      PH_OUTER: begin encl[0] = stop_at; ph = PH_VER; return; end
      PH_PDU: begin
        if (clen_seen != comm_cfg_len || !comm_ok) begin
          halt(ST_AUTH);
          return;
        end
        encl[1] = stop_at; ph = PH_REQID; return;
      end
      PH_VBL: begin encl[2] = stop_at; ph = PH_VB; return; end
      PH_VB:  begin encl[3] = stop_at; ph = PH_OID; return; end
      PH_VAL: begin ph = PH_DONE; return; end
      PH_VER: begin
        if (lacc != 1) begin
          halt(ST_PARSE);
          return;
        end
      end
      PH_COMM: clen_seen = lacc;
      default: ;
    endcase
    eend = stop_at;
    cidx = 0;
    hs = HS_CONTENT;
    if (lacc == 0) close_element();
  endtask

  task automatic content_byte(logic [7:0] b);
    logic [63:0] w;
    case (ph)
      PH_VER: ver = b;
      PH_COMM: begin
        w = comm_w[cidx / 8];
        if (cidx >= CommMax || w[(cidx % 8) * 8 +: 8] != b) comm_ok = 0;
      end
      PH_REQID: begin
        rid = {rid[55:0], b};
        if (rlen < ReqIdBytes) rlen++;
        else id_ovf = 1;
      end
      PH_OID: begin
        if (cidx < PrefixLen) begin
          if (PrefixBytes[cidx] != b) pfx_ok = 0;
        end else if (cidx == PrefixLen) met = b;
      end
      default: ;
    endcase
    if (cidx < 31) cidx++;
  endtask

  task automatic parse_byte(logic [7:0] b, int o);
    int c;
    if (ph == PH_DONE || ph == PH_HALT) return;
    case (hs)
      HS_TAG: begin
        if (ph != PH_OUTER && encl[parent_lvl(ph)] < o + 2) begin halt(ST_PARSE); return; end
        if (!tag_matches(ph, b)) begin halt(ST_PARSE); return; end
        hs = HS_LEN;
      end
      HS_LEN: begin
        if (b[7]) begin
          c = b[6:0];
          if (c == 0 || c > 2) begin halt(ST_PARSE); return; end
          if (ph != PH_OUTER && encl[parent_lvl(ph)] < o + 1 + c) begin
            halt(ST_PARSE);
            return;
          end
          lcnt = c; lacc = '0; hs = HS_LONG;
        end else begin
          lacc = {8'd0, b};
          header_complete(o);
        end
      end
      HS_LONG: begin
        lacc = {lacc[7:0], b};
        lcnt = (lcnt - 1) & 3;
        if (lcnt == 0) header_complete(o);
      end
      default: begin
        content_byte(b);
        if (o + 1 >= eend) close_element();
      end
    endcase
  endtask

  // one accepted byte; queues a result on the last byte of a datagram
  task automatic predict_byte(logic [7:0] b, logic last);
    int o;
    result_t r;
    o = offs;
    if (o >= MaxDatagram) halt(ST_PARSE);
    else begin
      parse_byte(b, o);
      offs = o + 1;
    end
    if (!last) return;
    r = '0;
    if (ekind == ST_PARSE) r.status = ST_PARSE;
    else if (ph == PH_DONE || ekind == ST_AUTH) begin
      if (encl[0] > o + 1) r.status = ST_PARSE;
      else if (ekind == ST_AUTH) r.status = ST_AUTH;
      else r.status = id_ovf ? ST_LONG_ID : ST_OK;
    end else r.status = ST_PARSE;
    if (r.status == ST_OK || r.status == ST_LONG_ID) begin
      r.metric = met; r.version = ver; r.req_id = rid; r.req_id_len = 4'(rlen);
    end
    result_q.push_back(r);
    clear_parse();
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, m_axis_tdata);
        fails++;
      end else begin
        e = result_q.pop_front();
        if (m_axis_tdata[1:0] != e.status) begin
          $display("%0t status exp %0d got %0d", $time, e.status, m_axis_tdata[1:0]);
          fails++;
        end
        if (m_axis_tdata[9:2] != e.metric) begin
          $display("%0t metric exp %h got %h", $time, e.metric, m_axis_tdata[9:2]);
          fails++;
        end
        if (m_axis_tdata[17:10] != e.version) begin
          $display("%0t version exp %h got %h", $time, e.version, m_axis_tdata[17:10]);
          fails++;
        end
        if (m_axis_tdata[81:18] != e.req_id) begin
          $display("%0t req id exp %h got %h", $time, e.req_id, m_axis_tdata[81:18]);
          fails++;
        end
        if (m_axis_tdata[85:82] != e.req_id_len) begin
          $display("%0t req id len exp %0d got %0d", $time, e.req_id_len,
                   m_axis_tdata[85:82]);
          fails++;
        end
      end
    end
  end

  // ---------------- drivers ----------------
  // valid stays high after a transfer unless a gap is drawn, so the next byte can follow at once
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      s_axis_tdata = 8'($urandom);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tlast = last;
    do @(posedge clk); while (!s_axis_tready);
    predict_byte(b, last);
  endtask

  task automatic send_datagram(byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // block idle: input released, every result in, then a wait for the output skid
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_COMM0: comm_w[0] = val;
      CFG_COMM1: comm_w[1] = val;
      CFG_COMM2: comm_w[2] = {8'h00, val[55:0]};
      default:   comm_cfg_len = val[4:0];
    endcase
  endtask

  task automatic load_community(logic [63:0] w0, w1, w2, int len);
    wait_idle();
    write_reg(CFG_COMM0, w0);
    write_reg(CFG_COMM1, w1);
    write_reg(CFG_COMM2, w2);
    write_reg(CFG_COMM_LEN, len);
  endtask

  // ---------------- datagram builder ----------------
  function automatic byte_q_t tlv(logic [7:0] tag, byte_q_t body);
    byte_q_t h;
    int n, form;
    n = body.size();
    form = $urandom_range(9);
    h.push_back(tag);
    if (n < 128 && form < 7) h.push_back(8'(n));
    else if (n < 256 && form < 9) begin
      h.push_back(8'h81); h.push_back(8'(n));
    end else begin
      h.push_back(8'h82); h.push_back(8'(n >> 8)); h.push_back(8'(n));
    end
    return {h, body};
  endfunction

  function automatic byte_q_t rand_bytes(int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  // well-formed get request; good_comm selects the configured community
  function automatic byte_q_t build_request(bit good_comm, int id_len, logic [7:0] metric);
    byte_q_t comm, oid, vb, pdu, pre;
    logic [63:0] w;
    int n;
    n = good_comm ? comm_cfg_len : $urandom_range(24);
    for (int i = 0; i < n; i++) begin
      w = comm_w[(i / 8) % 3];
      comm.push_back((good_comm && i < CommMax) ? w[(i % 8) * 8 +: 8] : 8'($urandom));
    end
    foreach (PrefixBytes[i]) oid.push_back(PrefixBytes[i]);
    oid.push_back(metric);
    vb = tlv(TagSeq, {tlv(TagOid, oid), tlv(8'($urandom), rand_bytes($urandom_range(3)))});
    pdu = {tlv(TagInt, rand_bytes(id_len)), tlv(8'($urandom), rand_bytes(1)),
           tlv(8'($urandom), rand_bytes(1)), tlv(TagSeq, vb)};
    pre = {8'(TagInt), 8'h01, 8'($urandom)};
    return tlv(TagSeq, {pre, tlv(TagOct, comm), tlv(TagPdu, pdu)});
  endfunction

  // mostly clean requests, some damaged, some noise
  function automatic byte_q_t random_datagram();
    byte_q_t q;
    int kind, id_len, p;
    id_len = ($urandom_range(9) == 0) ? $urandom_range(10) : $urandom_range(1, 8);
    q = build_request($urandom_range(9) != 0, id_len, 8'($urandom));
    kind = $urandom_range(19);
    p = $urandom_range(q.size() - 1);
    if (kind < 2) q[p] = 8'($urandom);
    else if (kind < 4) q[p] = q[p] ^ (8'h1 << $urandom_range(7));
    else if (kind < 6) q = q[0:p];
    else if (kind < 8) q = {q, rand_bytes($urandom_range(1, 6))};
    else if (kind < 9) q = rand_bytes($urandom_range(1, 40));
    return q;
  endfunction

  // ---------------- tests ----------------
  task automatic test_basic_requests();
    send_datagram(build_request(1, 4, 8'h07));
    send_datagram(build_request(1, 1, 8'hFF));
    send_datagram(build_request(1, 8, 8'h00));
    send_datagram(build_request(0, 4, 8'h01));
  endtask

  task automatic test_special_cases();
    byte_q_t q;
    // request id longer than kept width, and empty request id
    send_datagram(build_request(1, 10, 8'h33));
    send_datagram(build_request(1, 0, 8'h34));
    // datagram ends early
    q = build_request(1, 2, 8'h35);
    send_datagram(q[0:q.size() - 3]);
    send_datagram('{8'h30});
    // trailing bytes after the parse are ignored
    send_datagram({build_request(1, 3, 8'h36), rand_bytes(5)});
    // trailing bytes beyond the datagram limit
    q = build_request(1, 3, 8'h37);
    send_datagram({q, rand_bytes(MaxDatagram + 2 - q.size())});
  endtask

  task automatic test_random_traffic(int datagrams);
    repeat (datagrams) send_datagram(random_datagram());
  endtask

  task automatic test_idle_phases();
    int gaps [4] = '{0, 66, 0, 32};
    int stalls [4] = '{0, 0, 66, 32};
    for (int i = 0; i < 4; i++) begin
      gap_pct = gaps[i];
      stall_pct = stalls[i];
      test_random_traffic(4);
    end
  endtask

  task automatic test_community_settings();
    // empty community
    load_community('0, '0, '0, 0);
    test_random_traffic(4);
    // full 23-byte community, all ones
    load_community('1, '1, '1, CommMax);
    test_random_traffic(4);
    // length beyond the stored bytes rejects everything
    load_community({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 31);
    test_random_traffic(4);
  endtask

  initial begin
    comm_w = '{'0, '0, '0};
    comm_cfg_len = 0;
    clear_parse();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // "public"
    load_community(64'h0000_6369_6c62_7570, '0, '0, 6);
    test_basic_requests();
    test_special_cases();
    test_idle_phases();
    load_community({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   $urandom_range(1, CommMax));
    test_idle_phases();
    test_community_settings();
    wait_idle();
    if (fails == 0) $display("snmp_get_request_parser: match");
    else $display("snmp_get_request_parser: mismatch");
    $finish;
  end
endmodule
